FILE: rtl/core/knn_pkg.sv
// Shared constants, codes and types of the k-nearest-neighbor search core.
package knn_pkg;

	localparam int KNN_MAX_POINTS = 256;
	localparam int KNN_DIMENSION = 8;
	localparam int KNN_MAX_NEIGHBORS = 16;

	localparam int APB_ADDR_W = 3;
	localparam logic [APB_ADDR_W-1:0] ADDR_NEIGHBOR_COUNT = 3'd0;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_QUERY = 2'd2,
		ACT_INDEX = 2'd3
	} action_t;

	// Control of the top-k list: start empties it, insert offers one candidate.
	typedef struct packed {
		logic start;
		logic insert;
	} topk_ctl_t;

endpackage

FILE: rtl/core/knn_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module knn_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/knn_topk.sv
// Sorted list of the k best candidates, kept as a row of compare-and-shift cells.
module knn_topk #(
	parameter int MAX_NEIGHBORS = 16,
	parameter int DIST_W = 36,
	parameter int IDX_W = 8,
	localparam int KW = $clog2(MAX_NEIGHBORS + 1),
	localparam int NW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  knn_pkg::topk_ctl_t  ctl,
	input  logic [DIST_W-1:0]   ins_dist,
	input  logic [IDX_W-1:0]    ins_index,
	input  logic [KW-1:0]       k_lim,
	input  logic [NW-1:0]       rd_ptr,
	output logic [KW-1:0]       fill,
	output logic [IDX_W-1:0]    rd_index
);
	import knn_pkg::*;

	logic [DIST_W-1:0] dist_q [0:MAX_NEIGHBORS-1];
	logic [IDX_W-1:0]  idx_q  [0:MAX_NEIGHBORS-1];
	logic [KW-1:0]     fill_q;
	logic [MAX_NEIGHBORS-1:0] worse;

	// A cell is worse than the candidate when it is empty or strictly farther,
	// so equal distances keep the earlier (lower) index ahead.
	always_comb begin
		for (int p = 0; p < MAX_NEIGHBORS; p++) begin
			worse[p] = (KW'(p) >= fill_q) || (dist_q[p] > ins_dist);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.insert) begin
			if (worse[0]) begin
				dist_q[0] <= ins_dist;
				idx_q[0]  <= ins_index;
			end
			for (int p = 1; p < MAX_NEIGHBORS; p++) begin
				if (worse[p]) begin
					if (worse[p-1]) begin
						dist_q[p] <= dist_q[p-1];
						idx_q[p]  <= idx_q[p-1];
					end else begin
						dist_q[p] <= ins_dist;
						idx_q[p]  <= ins_index;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (ctl.start) begin
			fill_q <= '0;
		end else if (ctl.insert && (fill_q < k_lim)) begin
			fill_q <= fill_q + KW'(1);
		end
	end

	assign fill = fill_q;
	assign rd_index = idx_q[rd_ptr];

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= KW'(MAX_NEIGHBORS))
		else $error("top-k fill exceeds the list length");

endmodule

FILE: rtl/core/brute_force_k_nearest_neighbors_core.sv
// Brute-force k-nearest-neighbor core: point store in RAM, distance pipeline, top-k cells.
// Points and queries arrive one Q8.8 coordinate per word and are staged in a small
// buffer; staging words are taken one per cycle while the core is idle. Adding a point
// copies the staged vector into the point store. A query walks every stored point
// with one point-store read per cycle (a query by stored index first copies that
// point into the staging buffer and skips it in the walk). The k results then leave
// one per cycle while the output is taken. Errors give a single result word.
// No clearing pass is needed after reset.
module brute_force_k_nearest_neighbors_core #(
	parameter int MAX_POINTS = knn_pkg::KNN_MAX_POINTS,
	parameter int DIMENSION = knn_pkg::KNN_DIMENSION,
	parameter int MAX_NEIGHBORS = knn_pkg::KNN_MAX_NEIGHBORS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [1:0]                       action,
	input  logic signed [15:0]               coordinate,
	input  logic                             vector_last,
	input  logic [7:0]                       stored_index,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       neighbor_index,
	output logic                             result_last,
	output logic                             error_flag,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [knn_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [31:0]                      pwdata,
	output logic [31:0]                      prdata,
	output logic                             pready
);
	import knn_pkg::*;

	localparam int PW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int DW = (DIMENSION > 1) ? $clog2(DIMENSION) : 1;
	localparam int LW = $clog2(DIMENSION + 1);
	localparam int KW = $clog2(MAX_NEIGHBORS + 1);
	localparam int NW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
	localparam int SQW = 33;
	localparam int SW = SQW + $clog2(DIMENSION);
	localparam int TW = CW + KW;
	localparam int SAW = PW + DW;
	localparam int STORE_DEPTH = MAX_POINTS << DW;
	localparam logic [DW-1:0] COL_LAST = DW'(DIMENSION - 1);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_COPY   = 5'b00010,
		ST_ADD    = 5'b00100,
		ST_SEARCH = 5'b01000,
		ST_EMIT   = 5'b10000
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [DW-1:0] pos_q;
	logic [LW-1:0] qlen_q;
	logic [4:0]    nc_q;
	logic [KW-1:0] keff_q;
	logic          has_skip_q;
	logic [PW-1:0] skip_q;
	logic [CW-1:0] row_q;
	logic [DW-1:0] col_q;
	logic          run_q;
	logic          emit_err_q;
	logic [KW-1:0] ptr_q;

	logic          out_valid_q;
	logic [7:0]    out_index_q;
	logic          out_last_q;
	logic          out_error_q;

	logic          v_s1;
	logic [DW-1:0] col_s1;
	logic [PW-1:0] row_s1;
	logic          sv_s2;
	logic [DW-1:0] col_s2;
	logic [PW-1:0] row_s2;
	logic [SQW-1:0] sq_s2;
	logic [SW-1:0] acc_q;
	logic          sv_s3;
	logic [SW-1:0] dist_s3;
	logic [PW-1:0] row_s3;

	logic          in_fire;
	logic [KW-1:0] kc;
	logic          vec_end;
	logic [CW+7:0] sidx_w;
	logic [CW+7:0] cnt_w;
	logic          srch_avail;
	logic          skip_now;
	logic          s_issue;
	logic          c_issue;
	logic          emit_load;
	logic          emit_final;
	logic [PW+7:0] rd_ext;

	logic            store_we;
	logic [SAW-1:0]  store_waddr;
	logic [15:0]     store_wdata;
	logic [SAW-1:0]  store_raddr;
	logic [15:0]     store_rdata;
	logic            qbuf_we;
	logic [DW-1:0]   qbuf_waddr;
	logic [15:0]     qbuf_wdata;
	logic [15:0]     qbuf_rdata;
	logic [15:0]     qcoord;
	logic signed [16:0] diff;
	logic signed [33:0] prod;
	logic [SW-1:0]   acc_sum;

	topk_ctl_t     tk_ctl;
	logic [KW-1:0] tk_fill;
	logic [PW-1:0] tk_index;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_NEIGHBOR_COUNT) ? {27'd0, nc_q} : 32'd0;

	always_comb begin
		if (nc_q == 5'd0) begin
			kc = KW'(1);
		end else if (32'(nc_q) > MAX_NEIGHBORS) begin
			kc = KW'(MAX_NEIGHBORS);
		end else begin
			kc = KW'(nc_q);
		end
	end

	assign vec_end = vector_last || (pos_q == COL_LAST);
	assign sidx_w = {{CW{1'b0}}, stored_index};
	assign cnt_w = {8'd0, count_q};

	assign srch_avail = (state_q == ST_SEARCH) && (row_q < count_q);
	assign skip_now = has_skip_q && (row_q == CW'(skip_q));
	assign s_issue = srch_avail && !skip_now;
	assign c_issue = ((state_q == ST_COPY) || (state_q == ST_ADD)) && run_q;

	// Memory port steering.
	always_comb begin
		store_raddr = (state_q == ST_COPY) ? {skip_q, col_q} : {row_q[PW-1:0], col_q};
		store_we = (state_q == ST_ADD) && v_s1;
		store_waddr = {count_q[PW-1:0], col_s1};
		store_wdata = qcoord;
		if (state_q == ST_COPY) begin
			qbuf_we = v_s1;
			qbuf_waddr = col_s1;
			qbuf_wdata = store_rdata;
		end else begin
			qbuf_we = in_fire && ((action == ACT_ADD) || (action == ACT_QUERY));
			qbuf_waddr = pos_q;
			qbuf_wdata = coordinate;
		end
	end

	// Positions past the staged length read as zero, which pads short vectors.
	assign qcoord = (LW'(col_s1) < qlen_q) ? qbuf_rdata : 16'd0;
	assign diff = $signed({qcoord[15], qcoord}) - $signed({store_rdata[15], store_rdata});
	assign prod = diff * diff;
	assign acc_sum = ((col_s2 == '0) ? SW'(0) : acc_q) + SW'(sq_s2);

	knn_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (store_wdata),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	knn_ram #(.WIDTH(16), .DEPTH(DIMENSION)) u_qbuf (
		.clk   (clk),
		.we    (qbuf_we),
		.waddr (qbuf_waddr),
		.wdata (qbuf_wdata),
		.raddr (col_q),
		.rdata (qbuf_rdata)
	);

	assign tk_ctl.start = in_fire;
	assign tk_ctl.insert = sv_s3;

	knn_topk #(.MAX_NEIGHBORS(MAX_NEIGHBORS), .DIST_W(SW), .IDX_W(PW)) u_topk (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (tk_ctl),
		.ins_dist  (dist_s3),
		.ins_index (row_s3),
		.k_lim     (keff_q),
		.rd_ptr    (ptr_q[NW-1:0]),
		.fill      (tk_fill),
		.rd_index  (tk_index)
	);

	assign rd_ext = {8'd0, tk_index};
	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign emit_final = emit_err_q || ((ptr_q + KW'(1)) == tk_fill);

	// Distance pipeline: read, square, accumulate, insert.
	always_ff @(posedge clk) begin
		col_s1 <= col_q;
		row_s1 <= row_q[PW-1:0];
		col_s2 <= col_s1;
		row_s2 <= row_s1;
		sq_s2 <= prod[SQW-1:0];
		if (sv_s2) begin
			acc_q <= acc_sum;
		end
		dist_s3 <= acc_sum;
		row_s3 <= row_s2;
		if (emit_load) begin
			out_index_q <= emit_err_q ? 8'd0 : rd_ext[7:0];
			out_last_q <= emit_final;
			out_error_q <= emit_err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			sv_s2 <= 1'b0;
			sv_s3 <= 1'b0;
		end else begin
			v_s1 <= s_issue || c_issue;
			sv_s2 <= v_s1 && (state_q == ST_SEARCH);
			sv_s3 <= sv_s2 && (col_s2 == COL_LAST);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_q <= 5'd1;
		end else if (psel && penable && pwrite && pready && (paddr == ADDR_NEIGHBOR_COUNT)) begin
			nc_q <= pwdata[4:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			pos_q <= '0;
			qlen_q <= '0;
			keff_q <= KW'(1);
			has_skip_q <= 1'b0;
			skip_q <= '0;
			row_q <= '0;
			col_q <= '0;
			run_q <= 1'b0;
			emit_err_q <= 1'b0;
			ptr_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						keff_q <= kc;
						row_q <= '0;
						col_q <= '0;
						ptr_q <= '0;
						emit_err_q <= 1'b1;
						case (action)
							ACT_CLEAR: begin
								count_q <= '0;
								pos_q <= '0;
							end
							ACT_INDEX: begin
								pos_q <= '0;
								if ((sidx_w >= cnt_w) || (TW'(count_q) < (TW'(kc) + TW'(1)))) begin
									state_q <= ST_EMIT;
								end else begin
									skip_q <= sidx_w[PW-1:0];
									has_skip_q <= 1'b1;
									run_q <= 1'b1;
									state_q <= ST_COPY;
								end
							end
							default: begin
								if (!vec_end) begin
									pos_q <= pos_q + DW'(1);
								end else begin
									pos_q <= '0;
									qlen_q <= LW'(pos_q) + LW'(1);
									if (action == ACT_ADD) begin
										if (count_q == CW'(MAX_POINTS)) begin
											state_q <= ST_EMIT;
										end else begin
											run_q <= 1'b1;
											state_q <= ST_ADD;
										end
									end else if (TW'(count_q) < TW'(kc)) begin
										state_q <= ST_EMIT;
									end else begin
										has_skip_q <= 1'b0;
										state_q <= ST_SEARCH;
									end
								end
							end
						endcase
					end
				end
				ST_COPY, ST_ADD: begin
					if (c_issue) begin
						if (col_q == COL_LAST) begin
							col_q <= '0;
							run_q <= 1'b0;
						end else begin
							col_q <= col_q + DW'(1);
						end
					end else if (!v_s1) begin
						if (state_q == ST_ADD) begin
							count_q <= count_q + CW'(1);
							state_q <= ST_IDLE;
						end else begin
							qlen_q <= LW'(DIMENSION);
							row_q <= '0;
							state_q <= ST_SEARCH;
						end
					end
				end
				ST_SEARCH: begin
					if (srch_avail) begin
						if (skip_now) begin
							row_q <= row_q + CW'(1);
						end else if (col_q == COL_LAST) begin
							col_q <= '0;
							row_q <= row_q + CW'(1);
						end else begin
							col_q <= col_q + DW'(1);
						end
					end else if (!v_s1 && !sv_s2 && !sv_s3) begin
						emit_err_q <= 1'b0;
						ptr_q <= '0;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_load) begin
						ptr_q <= ptr_q + KW'(1);
						if (emit_final) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign neighbor_index = out_index_q;
	assign result_last = out_last_q;
	assign error_flag = out_error_q;

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!v_s1 && !sv_s2 && !sv_s3))
		else $error("word accepted while the distance pipeline is busy");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_POINTS))
		else $error("stored point count exceeds the store size");

	a_error_single: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_error_q) |-> out_last_q)
		else $error("error result not marked as the last of its run");

endmodule
